@@ design/rci_pkg.sv @@
package rci_pkg;

  // result format: unsigned Q16.16 ray parameter
  localparam int DIST_W    = 32;
  localparam int DIST_FRAC = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

@@ design/rci_in_if.sv @@
interface rci_in_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic        [COORD_WIDTH-2:0] radius;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;

  modport source (
    output valid, center_x, center_y, radius, start_x, start_y, dir_x, dir_y,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, radius, start_x, start_y, dir_x, dir_y,
    output ready
  );
endinterface

@@ design/rci_out_if.sv @@
interface rci_out_if import rci_pkg::*;;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DIST_W-1:0] distance;
  logic              saturated;

  modport source (
    output valid, hit, distance, saturated,
    input  ready
  );

  modport sink (
    input  valid, hit, distance, saturated,
    output ready
  );
endinterface

@@ design/rci_mul.sv @@
// Unsigned multiplier cut into four partial products, two register stages.
module rci_mul #(
  parameter int AW = 48,
  parameter int BW = 46
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;

  logic [AH+BH-1:0] pp_hh;
  logic [AH+BL-1:0] pp_hl;
  logic [AL+BH-1:0] pp_lh;
  logic [AL+BL-1:0] pp_ll;

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
      pp_hl <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      pp_lh <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
      pp_ll <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
    end
  end

  // stage 2: aligned sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= ((AW+BW)'(pp_hh) << (AL + BL)) + ((AW+BW)'(pp_hl) << AL)
         + ((AW+BW)'(pp_lh) << BL) + (AW+BW)'(pp_ll);
    end
  end
endmodule

@@ design/rci_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
module rci_sqrt #(
  parameter int ROOT_W = 47,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int RW = ROOT_W + 3;
  localparam int DW = 2 * ROOT_W;

  logic              vld    [0:ROOT_W-1];
  logic [DW-1:0]     rad_q  [0:ROOT_W-1];
  logic [RW-1:0]     rem_q  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [0:ROOT_W-1];
  logic [SIDE_W-1:0] side_q [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              cur_v;
    logic [DW-1:0]     cur_rad;
    logic [RW-1:0]     cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [SIDE_W-1:0] cur_side;
    logic [RW-1:0]     r4;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rad  = rad;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = vld[k-1];
      assign cur_rad  = rad_q[k-1];
      assign cur_rem  = rem_q[k-1];
      assign cur_root = root_q[k-1];
      assign cur_side = side_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign r4    = {cur_rem[RW-3:0], cur_rad[DW-1 -: 2]};
    assign trial = RW'({cur_root, 2'b01});
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= {cur_rad[DW-3:0], 2'b00};
        rem_q[k]  <= ge ? (r4 - trial) : r4;
        root_q[k] <= {cur_root[ROOT_W-2:0], ge};
        side_q[k] <= cur_side;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign out_side  = side_q[ROOT_W-1];
endmodule

@@ design/rci_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rci_div import rci_pkg::*; #(
  parameter int DVW    = 48,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DVW-1:0]    rem0,
  input  logic [DIST_W-1:0] low,
  input  logic [DVW-1:0]    divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DIST_W-1:0] quot,
  output logic [SIDE_W-1:0] out_side
);
  localparam int QW = DIST_W;

  logic              vld    [0:QW-1];
  logic [DVW-1:0]    rem_q  [0:QW-1];
  logic [QW-1:0]     low_q  [0:QW-1];
  logic [DVW-1:0]    dvs_q  [0:QW-1];
  logic [QW-1:0]     quot_q [0:QW-1];
  logic [SIDE_W-1:0] side_q [0:QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              cur_v;
    logic [DVW-1:0]    cur_rem;
    logic [QW-1:0]     cur_low;
    logic [DVW-1:0]    cur_dvs;
    logic [QW-1:0]     cur_quot;
    logic [SIDE_W-1:0] cur_side;
    logic [DVW:0]      r2;
    logic [DVW:0]      diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign cur_v    = in_valid;
      assign cur_rem  = rem0;
      assign cur_low  = low;
      assign cur_dvs  = divisor;
      assign cur_quot = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_v    = vld[k-1];
      assign cur_rem  = rem_q[k-1];
      assign cur_low  = low_q[k-1];
      assign cur_dvs  = dvs_q[k-1];
      assign cur_quot = quot_q[k-1];
      assign cur_side = side_q[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign r2   = {cur_rem, cur_low[QW-1]};
    assign diff = r2 - {1'b0, cur_dvs};
    assign ge   = (r2 >= {1'b0, cur_dvs});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[DVW-1:0] : r2[DVW-1:0];
        low_q[k]  <= {cur_low[QW-2:0], 1'b0};
        dvs_q[k]  <= cur_dvs;
        quot_q[k] <= {cur_quot[QW-2:0], ge};
        side_q[k] <= cur_side;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quot      = quot_q[QW-1];
  assign out_side  = side_q[QW-1];
endmodule

@@ design/ray_circle_intersection.sv @@
// Channel  Dir  Payload
// item     in   center_x, center_y, radius, start_x, start_y, dir_x, dir_y
// result   out  hit, distance (Q16.16), saturated
//
// One item per cycle. The pipeline depth is set by the root stages
// (2*COORD_WIDTH-1) and the 32 divider stages.
// Synchronous reset clears all valid bits, also those of the output stage.
// Output register plus one skid entry; when the skid entry fills, the whole
// pipeline holds and item.ready drops until result takes a transfer.
module ray_circle_intersection import rci_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input logic      clk,
  input logic      rst,
  rci_in_if.sink   item,
  rci_out_if.source result
);
  localparam int W      = COORD_WIDTH;
  localparam int AW     = 2 * W;
  localparam int HW     = 2 * W + 1;
  localparam int DDW    = 2 * W + 2;
  localparam int RRW    = 2 * W - 2;
  localparam int ARW    = AW + RRW;
  localparam int CRW    = 2 * HW;
  localparam int SW     = 2 * W - 1;
  localparam int NW     = 2 * W + 2;
  localparam int LW     = AW + DIST_FRAC;
  localparam int SIDE_W = 4 + AW + HW;

  logic en;
  logic skid_valid;

  assign en         = !skid_valid;
  assign item.ready = !skid_valid;

  // ---------------- stage 1: offsets and magnitudes
  logic signed [W:0] dx_c, dy_c;
  logic              v1;
  logic              ux_n, uy_n, dx_n, dy_n;
  logic [W-1:0]      mux, muy;
  logic [W:0]        mdx, mdy;
  logic [W-2:0]      r1;

  assign dx_c = $signed({item.start_x[W-1], item.start_x})
              - $signed({item.center_x[W-1], item.center_x});
  assign dy_c = $signed({item.start_y[W-1], item.start_y})
              - $signed({item.center_y[W-1], item.center_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_n <= item.dir_x[W-1];
      uy_n <= item.dir_y[W-1];
      dx_n <= dx_c[W];
      dy_n <= dy_c[W];
      mux  <= item.dir_x[W-1] ? (~item.dir_x + 1'b1) : item.dir_x;
      muy  <= item.dir_y[W-1] ? (~item.dir_y + 1'b1) : item.dir_y;
      mdx  <= dx_c[W] ? (~dx_c + 1'b1) : dx_c;
      mdy  <= dy_c[W] ? (~dy_c + 1'b1) : dy_c;
      r1   <= item.radius;
    end
  end

  // ---------------- stage 2: component products
  logic           v2;
  logic [AW-1:0]  pxx, pyy;
  logic [HW-1:0]  pxdx, pydy, pxdy, pydx;
  logic [DDW-1:0] pdxx, pdyy;
  logic [RRW-1:0] prr;
  logic           hna, hnb, cna, cnb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxx  <= AW'(mux) * AW'(mux);
      pyy  <= AW'(muy) * AW'(muy);
      pxdx <= HW'(mux) * HW'(mdx);
      pydy <= HW'(muy) * HW'(mdy);
      pxdy <= HW'(mux) * HW'(mdy);
      pydx <= HW'(muy) * HW'(mdx);
      pdxx <= DDW'(mdx) * DDW'(mdx);
      pdyy <= DDW'(mdy) * DDW'(mdy);
      prr  <= RRW'(r1) * RRW'(r1);
      hna  <= ux_n ^ dx_n;
      hnb  <= uy_n ^ dy_n;
      cna  <= ux_n ^ dy_n;
      cnb  <= !(uy_n ^ dx_n);
    end
  end

  // ---------------- stage 3: a, h, |cross|, sign of c
  logic [AW-1:0]  a_c;
  logic [HW-1:0]  hm_c, crm_c;
  logic           hneg_c;
  logic [DDW-1:0] dd_c;

  always_comb begin
    a_c  = pxx + pyy;
    dd_c = pdxx + pdyy;
    // h = dir . d in sign-magnitude
    if (hna == hnb) begin
      hm_c   = pxdx + pydy;
      hneg_c = hna;
    end else if (pxdx >= pydy) begin
      hm_c   = pxdx - pydy;
      hneg_c = hna;
    end else begin
      hm_c   = pydy - pxdx;
      hneg_c = hnb;
    end
    // cross product magnitude
    if (cna == cnb) begin
      crm_c = pxdy + pydx;
    end else if (pxdy >= pydx) begin
      crm_c = pxdy - pydx;
    end else begin
      crm_c = pydx - pxdy;
    end
  end

  logic           v3;
  logic [AW-1:0]  a3;
  logic [HW-1:0]  hm3, crm3;
  logic           hle0_3, cge3, cle3, nohit3;
  logic [RRW-1:0] rr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3     <= a_c;
      hm3    <= hm_c;
      crm3   <= crm_c;
      hle0_3 <= hneg_c || (hm_c == '0);
      cge3   <= dd_c >= DDW'(prr);
      cle3   <= dd_c <= DDW'(prr);
      nohit3 <= (a_c == '0);
      rr3    <= prr;
    end
  end

  // ---------------- stages 4-5: a*r^2 and cross^2
  logic [ARW-1:0] ar2;
  logic [CRW-1:0] cr2;

  rci_mul #(.AW(AW), .BW(RRW)) u_mul_ar (
    .clk (clk),
    .en  (en),
    .a   (a3),
    .b   (rr3),
    .p   (ar2)
  );

  rci_mul #(.AW(HW), .BW(HW)) u_mul_cr (
    .clk (clk),
    .en  (en),
    .a   (crm3),
    .b   (crm3),
    .p   (cr2)
  );

  // side data: {nohit, hle0, cge, cle, a, hm}
  logic [SIDE_W-1:0] side3, side4, side5;
  logic              v4, v5;

  assign side3 = {nohit3, hle0_3, cge3, cle3, a3, hm3};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4 <= side3;
      side5 <= side4;
    end
  end

  // ---------------- stage 6: discriminant
  logic              disc_neg;
  logic              v6;
  logic [ARW-1:0]    rad6;
  logic [SIDE_W-1:0] side6;

  assign disc_neg = CRW'(ar2) < cr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad6  <= ar2 - cr2[ARW-1:0];
      side6 <= {side5[SIDE_W-1] | disc_neg, side5[SIDE_W-2:0]};
    end
  end

  // ---------------- square root stages
  logic              v7;
  logic [SW-1:0]     s7;
  logic [SIDE_W-1:0] side7;

  rci_sqrt #(.ROOT_W(SW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .rad       (rad6),
    .in_side   (side6),
    .out_valid (v7),
    .root      (s7),
    .out_side  (side7)
  );

  // ---------------- stage 8: root choice and range check
  logic          nohit7, hle0_7, cge7, cle7;
  logic [AW-1:0] a7;
  logic [HW-1:0] hm7;
  logic [NW-1:0] n_c;
  logic          hit_c;

  assign {nohit7, hle0_7, cge7, cle7, a7, hm7} = side7;

  always_comb begin
    if (hle0_7 && cge7) begin
      n_c = NW'(hm7) - NW'(s7);
    end else if (hle0_7) begin
      n_c = NW'(hm7) + NW'(s7);
    end else begin
      n_c = NW'(s7) - NW'(hm7);
    end
    hit_c = !nohit7 && (hle0_7 || cle7);
  end

  logic              v8;
  logic [AW-1:0]     rem8, a8;
  logic [DIST_W-1:0] low8;
  logic              hit8, sat8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem8 <= AW'(n_c[NW-1:DIST_FRAC]);
      low8 <= {n_c[DIST_FRAC-1:0], {(DIST_W-DIST_FRAC){1'b0}}};
      a8   <= a7;
      hit8 <= hit_c;
      sat8 <= LW'(n_c) >= {a7, {DIST_FRAC{1'b0}}};
    end
  end

  // ---------------- divider stages
  logic              v9;
  logic [DIST_W-1:0] q9;
  logic              hit9, sat9;

  rci_div #(.DVW(AW), .SIDE_W(2)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v8),
    .rem0      (rem8),
    .low       (low8),
    .divisor   (a8),
    .in_side   ({hit8, sat8}),
    .out_valid (v9),
    .quot      (q9),
    .out_side  ({hit9, sat9})
  );

  // ---------------- output register and skid entry
  logic              new_hit, new_sat;
  logic [DIST_W-1:0] new_dist;
  logic              out_valid;
  logic              out_hit, out_sat, skid_hit, skid_sat;
  logic [DIST_W-1:0] out_dist, skid_dist;

  assign new_hit  = hit9;
  assign new_sat  = hit9 && sat9;
  assign new_dist = !hit9 ? '0 : (sat9 ? DIST_MAX : q9);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        out_hit    <= skid_hit;
        out_sat    <= skid_sat;
        out_dist   <= skid_dist;
        skid_valid <= 1'b0;
      end
    end else if (v9) begin
      if (!out_valid || result.ready) begin
        out_hit   <= new_hit;
        out_sat   <= new_sat;
        out_dist  <= new_dist;
        out_valid <= 1'b1;
      end else begin
        skid_hit   <= new_hit;
        skid_sat   <= new_sat;
        skid_dist  <= new_dist;
        skid_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid     = out_valid;
  assign result.hit       = out_hit;
  assign result.distance  = out_dist;
  assign result.saturated = out_sat;
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rci_pkg::*;

  localparam int CW         = 24;
  localparam int LATENCY    = 2 * CW + 39;
  localparam int N_RANDOM   = 1230;

  typedef struct {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [CW-2:0] radius;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
  } ray_test_t;

  typedef struct {
    logic              hit;
    logic [DIST_W-1:0] distance;
    logic              saturated;
  } hit_report_t;

  typedef struct {
    ray_test_t   test;
    logic        typed;
    hit_report_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  rci_in_if #(.COORD_WIDTH(CW)) item_if();
  rci_out_if                    result_if();

  ray_circle_intersection #(.COORD_WIDTH(CW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  hit_report_t pending_hits[$];
  int          n_errors;
  int          n_results;
  int          n_hits;
  int          n_saturated;
  int          send_idle_pct;
  int          recv_stall_pct;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ray/circle solver: exact integer quadratic, floor sqrt, floor divide
  function automatic hit_report_t solve_ray_circle(ray_test_t t);
    logic signed [127:0] dx, dy, ux, uy, rr, a, h, c, cr, disc, root, cand, n;
    hit_report_t res;
    res = '{hit: 1'b0, distance: '0, saturated: 1'b0};
    dx = t.start_x - t.center_x;
    dy = t.start_y - t.center_y;
    ux = t.dir_x;
    uy = t.dir_y;
    rr = $signed({105'd0, t.radius});
    a  = ux * ux + uy * uy;
    if (a == 0) return res;
    h    = ux * dx + uy * dy;
    c    = dx * dx + dy * dy - rr * rr;
    cr   = ux * dy - uy * dx;
    disc = a * rr * rr - cr * cr;
    if (disc < 0) return res;
    root = 0;
    for (int b = 55; b >= 0; b--) begin
      cand = root | (128'sd1 <<< b);
      if (cand * cand <= disc) root = cand;
    end
    // near root when the start is outside or on the circle and heading in
    if (h <= 0 && c >= 0) n = -h - root;
    else if (h <= 0 || c <= 0) n = -h + root;
    else return res;
    res.hit = 1'b1;
    if (n >= (a <<< DIST_FRAC)) begin
      res.distance  = DIST_MAX;
      res.saturated = 1'b1;
    end else begin
      res.distance = DIST_W'((n <<< DIST_FRAC) / a);
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
             $time, n_results, field, got, want);
    n_errors++;
  endtask

  // one transfer on the item channel, then an optional random gap
  task automatic send_test(ray_test_t t, logic typed, hit_report_t want);
    item_if.valid    <= 1'b1;
    item_if.center_x <= t.center_x;
    item_if.center_y <= t.center_y;
    item_if.radius   <= t.radius;
    item_if.start_x  <= t.start_x;
    item_if.start_y  <= t.start_y;
    item_if.dir_x    <= t.dir_x;
    item_if.dir_y    <= t.dir_y;
    do @(posedge clk); while (!item_if.ready);
    pending_hits.push_back(typed ? want : solve_ray_circle(t));
    if ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_hits.size() == 0) begin
        $display("[%0t] UNEXPECTED result, nothing pending", $time);
        n_errors++;
      end else begin
        hit_report_t want;
        want = pending_hits.pop_front();
        if (result_if.hit !== want.hit)
          report_mismatch("hit", result_if.hit, want.hit);
        if (result_if.distance !== want.distance)
          report_mismatch("distance", result_if.distance, want.distance);
        if (result_if.saturated !== want.saturated)
          report_mismatch("saturated", result_if.saturated, want.saturated);
        n_hits      += want.hit;
        n_saturated += want.saturated;
      end
      n_results++;
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic ray_test_t random_test();
    ray_test_t t;
    int mode;
    mode = $urandom_range(9);
    t.center_x = CW'($urandom); t.center_y = CW'($urandom);
    t.radius   = (CW-1)'($urandom);
    t.start_x  = CW'($urandom); t.start_y  = CW'($urandom);
    t.dir_x    = CW'($urandom); t.dir_y    = CW'($urandom);
    if (mode < 6) begin
      // geometry on a shared scale so rays actually hit
      int sh;
      sh = $urandom_range(20, 8);
      t.center_x = $signed(t.center_x) >>> (23 - sh);
      t.center_y = $signed(t.center_y) >>> (23 - sh);
      t.radius   = t.radius >> (22 - sh);
      t.start_x  = $signed(t.start_x) >>> (23 - sh);
      t.start_y  = $signed(t.start_y) >>> (23 - sh);
      t.dir_x    = $signed(t.dir_x) >>> $urandom_range(23, 4);
      t.dir_y    = $signed(t.dir_y) >>> $urandom_range(23, 4);
      if (mode == 0) begin
        t.start_x = t.center_x;
        t.start_y = t.center_y;
      end
    end else if (mode == 6) begin
      t.dir_x = $urandom_range(1) ? '0 : t.dir_x;
      t.dir_y = '0;
    end
    return t;
  endfunction

  // directed rows; typed expectations only where obvious
  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE  = 24'sh001000;
  localparam hit_report_t NO_HIT  = '{1'b0, 32'h0, 1'b0};
  localparam hit_report_t SAT_HIT = '{1'b1, DIST_MAX, 1'b1};
  localparam hit_report_t UNIT    = '{1'b1, 32'h0001_0000, 1'b0};

  stim_row_t directed[] = '{
    '{'{0, 0, 23'h001000, 0, 0, 0, 0},              1, NO_HIT},   // zero direction
    '{'{MAXC, MINC, '1, MINC, MAXC, 0, 0},          1, NO_HIT},   // zero dir, extremes
    '{'{0, 0, 23'h001000, 0, 0, ONE, 0},            1, UNIT},     // from center, unit
    '{'{0, 0, 23'h001000, 0, 0, 0, -ONE},           1, UNIT},
    '{'{0, 24'sh010000, 23'h001000, 0, 0, ONE, 0},  1, NO_HIT},   // clear miss
    '{'{MAXC, 0, 0, MINC, 0, 24'sd1, 0},            1, SAT_HIT},  // too far
    '{'{0, 0, 23'h001000, 24'sh003000, 0, ONE, 0},  1, NO_HIT},   // circle behind
    '{'{0, 0, 23'h001000, -24'sh003000, 0, ONE, 0}, 0, NO_HIT},   // near root
    '{'{0, 0, 23'h001000, -24'sh001000, 0, ONE, 0}, 0, NO_HIT},   // start on circle
    '{'{0, 0, 23'h001000, 24'sh001000, 0, ONE, 0},  0, NO_HIT},   // on circle, leaving
    '{'{0, ONE, 23'h001000, -24'sh003000, 0, ONE, 0}, 0, NO_HIT}, // tangent
    '{'{0, 0, '1, 0, 0, MAXC, MAXC},                0, NO_HIT},   // max radius
    '{'{0, 0, '1, 0, 0, MINC, MINC},                0, NO_HIT},
    '{'{MINC, MINC, '1, MAXC, MAXC, MINC, MINC},    0, NO_HIT},
    '{'{MAXC, MAXC, '1, MINC, MINC, MAXC, MAXC},    0, NO_HIT},
    '{'{MINC, MAXC, 23'h000001, MAXC, MINC, MINC, MAXC}, 0, NO_HIT},
    '{'{0, 0, 23'h000001, 0, 0, 24'sd1, 24'sd1},    0, NO_HIT},   // tiny
    '{'{0, 0, 0, 0, 0, ONE, ONE},                   0, NO_HIT},   // zero radius at start
    '{'{ONE, ONE, 23'h000800, 0, 0, ONE, ONE},      0, NO_HIT},
    '{'{-ONE, ONE, 23'h002000, ONE, -ONE, -ONE, ONE}, 0, NO_HIT}
  };

  // stimulus
  initial begin
    hit_report_t none;
    none = NO_HIT;
    rst = 1'b1;
    n_errors = 0; n_results = 0; n_hits = 0; n_saturated = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 86;
    item_if.valid <= 1'b0;
    item_if.center_x <= '0; item_if.center_y <= '0; item_if.radius <= '0;
    item_if.start_x  <= '0; item_if.start_y  <= '0;
    item_if.dir_x    <= '0; item_if.dir_y    <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_test(directed[i].test, directed[i].typed, directed[i].want);
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3) begin
        send_idle_pct  = 86;
        recv_stall_pct = 10;
      end else if (k == 2 * N_RANDOM / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_test(random_test(), 1'b0, none);
    end
    item_if.valid <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Checked %0d transfers under three idle/stall mixes", n_results);
    $display("  %0d hits, %0d saturated, rest misses or zero direction",
             n_hits, n_saturated);
    if (n_errors == 0) begin
      $display("ray_circle_intersection regression: pass");
    end else begin
      $display("ray_circle_intersection regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3ms;
    $display("Timeout with %0d results pending", pending_hits.size());
    $display("ray_circle_intersection regression: fail");
    $finish;
  end

endmodule
